@@ rtl/cpt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the Clarke/Park transform.
// No dependencies; every other file of the block imports this package.
package cpt_pkg;

  localparam int DW        = 16;               // Q1.15 data
  localparam int ANGLE_W   = 16;               // angle, full scale is one turn
  localparam int SIN_BITS  = 10;               // angle bits used for the lookup
  localparam int QBITS     = SIN_BITS - 2;
  localparam int QLEN      = 1 << QBITS;       // quarter-wave entries minus one
  localparam int MUL_W     = 20;               // shared multiplier operand width
  localparam int ACC_W     = 2 * MUL_W;        // product and accumulator width
  localparam int WIDE_W    = DW + 2;           // unsaturated alpha/beta, U+2V sum

  localparam int PROD_SH    = DW - 1;          // Q1.15 x Q1.15 back to Q1.15
  localparam int CLARKE_SH  = 16;              // 1/sqrt3 is in Q16
  localparam int ICLARKE_SH = 17;              // sqrt3 in Q16, and the halving
  localparam int ALPHA_SH   = 16;              // alpha * 65536

  localparam int K_INV_SQRT3 = 37837;          // 1/sqrt3 * 2^16
  localparam int K_SQRT3     = 113512;         // sqrt3 * 2^16

  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (DW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // table generation, elaboration only
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SIN_MAX     = (64'd1 << (DW - 1)) - 64'd1;
  localparam int          HORNER_N    = 6;
  localparam logic [63:0] HORNER_DIV [HORNER_N] = '{64'd156, 64'd110, 64'd72,
                                                    64'd42, 64'd20, 64'd6};

  typedef logic signed [DW-1:0] data_t;
  typedef logic [ANGLE_W-1:0]   angle_t;
  typedef logic [DW-1:0]        sin_tab_t [0:QLEN];

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    MUL_UV_K,
    MUL_CS_AL,
    MUL_SN_BE,
    MUL_CS_BE,
    MUL_SN_AL,
    MUL_CS_HD,
    MUL_SN_HQ,
    MUL_SN_HD,
    MUL_CS_HQ,
    MUL_BE_SQ3
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_NEG_AL
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_BETA_C,
    WR_D,
    WR_Q,
    WR_ALPHA,
    WR_BETA_I,
    WR_PHASES
  } wr_sel_t;

  typedef struct packed {
    logic     load;
    logic     sin_ld;
    logic     cos_ld;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    wr_sel_t  wr_sel;
    logic     out_ld;
  } cmd_t;

  // round to nearest, ties toward plus infinity, then arithmetic shift
  function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] x,
                                                   input int s);
    logic signed [ACC_W-1:0] half;
    half = ACC_W'(1) << (s - 1);
    return (x + half) >>> s;
  endfunction

  function automatic data_t sat(input logic signed [ACC_W-1:0] x);
    data_t r;
    if (x > SAT_HI) begin
      r = SAT_HI[DW-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  // quarter-wave sine, Q30 Horner series to x^13, scaled to full Q1.15
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    for (int k = 0; k <= QLEN; k++) begin
      x  = (HALF_PI_Q30 * 64'(k)) / QLEN;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < HORNER_N; i++) begin
        t = Q30_ONE - ((x2 * t) >> 30) / HORNER_DIV[i];
      end
      s = (x * t) >> 30;
      e = (s * SIN_MAX + (64'd1 << 29)) >> 30;
      tab[k] = (e > SIN_MAX) ? SIN_MAX[DW-1:0] : e[DW-1:0];
    end
    return tab;
  endfunction

endpackage

@@ rtl/cpt_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the Clarke/Park transform: valid/ready plus one item.
// Depends on cpt_pkg.
interface cpt_in_if;
  import cpt_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  data_t  phase_u;
  data_t  phase_v;
  angle_t rotor_angle;
  data_t  d_delta;
  data_t  q_delta;

  modport source (output valid, operation, phase_u, phase_v, rotor_angle, d_delta,
                  q_delta, input ready);
  modport sink   (input valid, operation, phase_u, phase_v, rotor_angle, d_delta,
                  q_delta, output ready);
endinterface

@@ rtl/cpt_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the Clarke/Park transform: valid/ready plus one item.
// Depends on cpt_pkg.
interface cpt_out_if;
  import cpt_pkg::*;

  logic  valid;
  logic  ready;
  data_t d_out;
  data_t q_out;
  data_t u_out;
  data_t v_out;
  data_t w_out;

  modport source (output valid, d_out, q_out, u_out, v_out, w_out, input ready);
  modport sink   (input valid, d_out, q_out, u_out, v_out, w_out, output ready);
endinterface

@@ rtl/clarke_park_transform.sv @@
`timescale 1ns / 1ps
// Clarke/Park current-vector transform for field-oriented control, Q1.15 data.
//
// Channels: in_ch takes one item per transform; operation selects forward
// (phase U, V and rotor angle to d/q, angle stored) or inverse (d/q deltas added
// to the stored d/q with saturation, then inverse Park and inverse Clarke to U,
// V, W). out_ch returns one item for every input item, in order.
// Sequencing: each item runs through its step sequence, forward or inverse, on
// the single shared 20x20 multiplier and the one sine/cosine table port.
// in_ch.ready is high only while the sequencer is idle, so a new item is taken
// only once the previous item's result has gone to the output register.
// Stall: the result sits in its own output register; a new item is taken while
// it waits. If a second result finishes before the first is taken, the
// sequencer holds it and keeps in_ch.ready low until the register frees.
// Reset (rst_n low, synchronous): stored angle, d and q clear to zero, no result
// is pending, and the sequencer returns to idle, so in_ch.ready is high.
// Depends on cpt_pkg, cpt_in_if, cpt_out_if, cpt_ctrl and cpt_datapath.
module clarke_park_transform (
  input  logic      clk,
  input  logic      rst_n,
  cpt_in_if.sink    in_ch,
  cpt_out_if.source out_ch
);
  import cpt_pkg::*;

  cmd_t cmd;

  cpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .operation (in_ch.operation),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cpt_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .operation   (in_ch.operation),
    .phase_u     (in_ch.phase_u),
    .phase_v     (in_ch.phase_v),
    .rotor_angle (in_ch.rotor_angle),
    .d_delta     (in_ch.d_delta),
    .q_delta     (in_ch.q_delta),
    .d_out       (out_ch.d_out),
    .q_out       (out_ch.q_out),
    .u_out       (out_ch.u_out),
    .v_out       (out_ch.v_out),
    .w_out       (out_ch.w_out)
  );

endmodule

@@ rtl/cpt_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the Clarke/Park transform: handshakes and per-step datapath commands.
// Depends on cpt_pkg.
module cpt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpt_pkg::op_t    operation,
  output logic            out_valid,
  input  logic            out_ready,
  output cpt_pkg::cmd_t   cmd
);
  import cpt_pkg::*;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] FWD_LAST = STEP_W'(8);
  localparam logic [STEP_W-1:0] INV_LAST = STEP_W'(10);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;
  op_t                 op_r;
  logic                out_valid_r;

  logic accept;
  logic last;
  logic out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign last      = (op_r == OP_INV) ? (step_r == INV_LAST) : (step_r == FWD_LAST);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_UV_K;
    cmd.acc_op  = ACC_HOLD;
    cmd.wr_sel  = WR_NONE;
    cmd.load    = accept;
    if (state_r == S_RUN) begin
      if (op_r == OP_FWD) begin
        case (step_r)
          4'd1: begin cmd.sin_ld = 1'b1; cmd.mul_sel = MUL_UV_K; end
          4'd2: begin cmd.cos_ld = 1'b1; cmd.wr_sel = WR_BETA_C; end
          4'd3: begin cmd.mul_sel = MUL_CS_AL; end
          4'd4: begin cmd.acc_op = ACC_LOAD; cmd.mul_sel = MUL_SN_BE; end
          4'd5: begin cmd.acc_op = ACC_ADD; cmd.mul_sel = MUL_CS_BE; end
          4'd6: begin
            cmd.wr_sel  = WR_D;
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_SN_AL;
          end
          4'd7: begin cmd.acc_op = ACC_SUB; end
          4'd8: begin cmd.wr_sel = WR_Q; end
          default: begin cmd.acc_op = ACC_HOLD; end
        endcase
      end else begin
        case (step_r)
          4'd1: begin cmd.sin_ld = 1'b1; end
          4'd2: begin cmd.cos_ld = 1'b1; end
          4'd3: begin cmd.mul_sel = MUL_CS_HD; end
          4'd4: begin cmd.acc_op = ACC_LOAD; cmd.mul_sel = MUL_SN_HQ; end
          4'd5: begin cmd.acc_op = ACC_SUB; cmd.mul_sel = MUL_SN_HD; end
          4'd6: begin
            cmd.wr_sel  = WR_ALPHA;
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_CS_HQ;
          end
          4'd7: begin cmd.acc_op = ACC_ADD; end
          4'd8: begin cmd.wr_sel = WR_BETA_I; end
          4'd9: begin cmd.mul_sel = MUL_BE_SQ3; cmd.acc_op = ACC_NEG_AL; end
          4'd10: begin cmd.wr_sel = WR_PHASES; end
          default: begin cmd.acc_op = ACC_HOLD; end
        endcase
      end
    end
    // result register loads from the datapath's next values, so the last
    // write step and the load can share a cycle
    cmd.out_ld = (((state_r == S_RUN) && last) || (state_r == S_WAIT)) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      op_r        <= OP_FWD;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= operation;
            step_r  <= STEP_W'(1);
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          step_r <= step_r + STEP_W'(1);
          if (last) begin
            state_r <= out_free ? S_IDLE : S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/cpt_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the Clarke/Park transform: held angle/d/q, sine lookup, one shared
// multiplier with accumulator, rounding/saturation and the result register.
// Depends on cpt_pkg; driven by cpt_ctrl.
module cpt_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  cpt_pkg::cmd_t   cmd,
  input  cpt_pkg::op_t    operation,
  input  cpt_pkg::data_t  phase_u,
  input  cpt_pkg::data_t  phase_v,
  input  cpt_pkg::angle_t rotor_angle,
  input  cpt_pkg::data_t  d_delta,
  input  cpt_pkg::data_t  q_delta,
  output cpt_pkg::data_t  d_out,
  output cpt_pkg::data_t  q_out,
  output cpt_pkg::data_t  u_out,
  output cpt_pkg::data_t  v_out,
  output cpt_pkg::data_t  w_out
);
  import cpt_pkg::*;

  localparam sin_tab_t SIN_TAB = build_sin_tab();
  localparam logic signed [MUL_W-1:0] K_INV = MUL_W'(K_INV_SQRT3);
  localparam logic signed [MUL_W-1:0] K_SQ3 = MUL_W'(K_SQRT3);

  // architectural state
  angle_t held_angle_r;
  data_t  held_d_r, held_d_nxt;
  data_t  held_q_r, held_q_nxt;

  // working registers
  data_t                    pu_r;
  logic signed [WIDE_W-1:0] uv_r;
  data_t                    sn_r;
  data_t                    cs_r;
  logic signed [WIDE_W-1:0] be_r, be_nxt;
  logic signed [WIDE_W-1:0] al_r, al_nxt;
  logic signed [ACC_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  data_t                    u_r, u_nxt;
  data_t                    v_r, v_nxt;
  data_t                    w_r, w_nxt;

  // result register
  data_t d_out_r, q_out_r, u_out_r, v_out_r, w_out_r;

  // sine/cosine lookup
  logic [SIN_BITS-1:0] base_idx;
  logic [SIN_BITS-1:0] lk_idx;
  logic [1:0]          quad;
  logic [QBITS-1:0]    pos;
  logic [QBITS:0]      tab_addr;
  logic [DW-1:0]       mag;
  data_t               trig;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] prod;

  assign base_idx = held_angle_r[ANGLE_W-1 -: SIN_BITS];
  assign lk_idx   = cmd.cos_ld ? base_idx + SIN_BITS'(QLEN) : base_idx;
  assign quad     = lk_idx[SIN_BITS-1 -: 2];
  assign pos      = lk_idx[QBITS-1:0];
  // the second and fourth quadrants read the table backward
  assign tab_addr = quad[0] ? ((QBITS+1)'(QLEN) - {1'b0, pos}) : {1'b0, pos};
  assign mag      = SIN_TAB[tab_addr];
  assign trig     = quad[1] ? -$signed(mag) : $signed(mag);

  always_comb begin
    case (cmd.mul_sel)
      MUL_UV_K:   begin mul_a = MUL_W'(uv_r); mul_b = K_INV;           end
      MUL_CS_AL:  begin mul_a = MUL_W'(cs_r); mul_b = MUL_W'(pu_r);     end
      MUL_SN_BE:  begin mul_a = MUL_W'(sn_r); mul_b = MUL_W'(be_r);     end
      MUL_CS_BE:  begin mul_a = MUL_W'(cs_r); mul_b = MUL_W'(be_r);     end
      MUL_SN_AL:  begin mul_a = MUL_W'(sn_r); mul_b = MUL_W'(pu_r);     end
      MUL_CS_HD:  begin mul_a = MUL_W'(cs_r); mul_b = MUL_W'(held_d_r); end
      MUL_SN_HQ:  begin mul_a = MUL_W'(sn_r); mul_b = MUL_W'(held_q_r); end
      MUL_SN_HD:  begin mul_a = MUL_W'(sn_r); mul_b = MUL_W'(held_d_r); end
      MUL_CS_HQ:  begin mul_a = MUL_W'(cs_r); mul_b = MUL_W'(held_q_r); end
      MUL_BE_SQ3: begin mul_a = MUL_W'(be_r); mul_b = K_SQ3;           end
      default:    begin mul_a = '0;           mul_b = '0;              end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD:   acc_nxt = prod_r;
      ACC_ADD:    acc_nxt = acc_r + prod_r;
      ACC_SUB:    acc_nxt = acc_r - prod_r;
      ACC_NEG_AL: acc_nxt = -(ACC_W'(al_r) <<< ALPHA_SH);
      default:    acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    held_d_nxt = held_d_r;
    held_q_nxt = held_q_r;
    be_nxt     = be_r;
    al_nxt     = al_r;
    u_nxt      = u_r;
    v_nxt      = v_r;
    w_nxt      = w_r;
    if (cmd.load) begin
      u_nxt = '0;
      v_nxt = '0;
      w_nxt = '0;
      if (operation == OP_INV) begin
        held_d_nxt = sat(ACC_W'(held_d_r) + ACC_W'(d_delta));
        held_q_nxt = sat(ACC_W'(held_q_r) + ACC_W'(q_delta));
      end
    end
    case (cmd.wr_sel)
      WR_BETA_C: be_nxt = WIDE_W'(sat(rshr(prod_r, CLARKE_SH)));
      WR_D:      held_d_nxt = sat(rshr(acc_r, PROD_SH));
      WR_Q:      held_q_nxt = sat(rshr(acc_r, PROD_SH));
      WR_ALPHA:  al_nxt = WIDE_W'(rshr(acc_r, PROD_SH));
      WR_BETA_I: be_nxt = WIDE_W'(rshr(acc_r, PROD_SH));
      WR_PHASES: begin
        // acc holds -alpha*2^16, prod holds beta*sqrt3*2^16
        u_nxt = sat(ACC_W'(al_r));
        v_nxt = sat(rshr(acc_r + prod_r, ICLARKE_SH));
        w_nxt = sat(rshr(acc_r - prod_r, ICLARKE_SH));
      end
      default: be_nxt = be_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_angle_r <= '0;
      held_d_r     <= '0;
      held_q_r     <= '0;
    end else begin
      if (cmd.load && (operation == OP_FWD)) begin
        held_angle_r <= rotor_angle;
      end
      held_d_r <= held_d_nxt;
      held_q_r <= held_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pu_r <= phase_u;
      uv_r <= WIDE_W'(phase_u) + (WIDE_W'(phase_v) <<< 1);
    end
    if (cmd.sin_ld) begin
      sn_r <= trig;
    end
    if (cmd.cos_ld) begin
      cs_r <= trig;
    end
    prod_r <= prod;
    acc_r  <= acc_nxt;
    be_r   <= be_nxt;
    al_r   <= al_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    w_r    <= w_nxt;
    if (cmd.out_ld) begin
      d_out_r <= held_d_nxt;
      q_out_r <= held_q_nxt;
      u_out_r <= u_nxt;
      v_out_r <= v_nxt;
      w_out_r <= w_nxt;
    end
  end

  assign d_out = d_out_r;
  assign q_out = q_out_r;
  assign u_out = u_out_r;
  assign v_out = v_out_r;
  assign w_out = w_out_r;

endmodule
